### design/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SFS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sfs assertion failed");

// next-cycle implication, off while reset is asserted
`define SFS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sfs assertion failed");

// next-cycle implication that also holds across reset
`define SFS_ASSERT_ALWAYS_NEXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("sfs assertion failed");

`endif

### design/sfs_pkg.sv
package sfs_pkg;

  // request codes on the input channel
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_HOLD    = 3'd1;
  localparam logic [2:0] REQ_RESTART = 3'd2;
  localparam logic [2:0] REQ_SET     = 3'd3;
  localparam logic [2:0] REQ_STOP    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAMES  = 3'd0;
  localparam logic [2:0] CFG_FIRST   = 3'd1;
  localparam logic [2:0] CFG_LAST    = 3'd2;
  localparam logic [2:0] CFG_REVERSE = 3'd3;
  localparam logic [2:0] CFG_BOUNCE  = 3'd4;
  localparam logic [2:0] CFG_LOOP    = 3'd5;
  localparam logic [2:0] CFG_SPEED   = 3'd6;

  // widths of the time values
  localparam int HOLD_W    = 26;  // hold time in us, 65535 ms * 1000
  localparam int INC_W     = 24;  // tick increment in us after the q8 scale
  localparam int ELAPSED_W = 32;

  localparam logic [9:0] MS_TO_US = 10'd1000;
  localparam logic [15:0] SPEED_NORMAL = 16'd256;

  // decoded operation carried through the queue
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_HOLD    = 3'd1,
    OP_RESTART = 3'd2,
    OP_SET     = 3'd3,
    OP_STOP    = 3'd4,
    OP_NOP     = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               no_time;      // tick with zero delta or zero speed
    logic signed [6:0]  frame_index;
    logic [HOLD_W-1:0]  arg;          // hold in us, or tick increment in us
  } cmd_t;

  typedef struct packed {
    logic [6:0]  frames_in_sheet;
    logic [5:0]  range_first;
    logic [5:0]  range_last;
    logic        range_reverse;
    logic        range_bounce;
    logic        loop_enable;
    logic [15:0] speed_q8;
  } cfg_t;

  typedef struct packed {
    logic signed [6:0] shown_frame;
    logic              finished;
    logic              playing;
    logic [8:0]        steps_taken;
  } res_t;

endpackage

### design/sfs_front.sv
module sfs_front
  import sfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [15:0]       in_delta_us,
  input  logic signed [6:0] in_frame_index,
  input  logic [15:0]       in_duration_ms,
  input  logic [15:0]       speed_q8,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd
);

  logic        front_v_r;
  cmd_t        cmd_r;
  cmd_t        cmd_nxt;
  logic        accept;
  logic [15:0] dur_fix;
  logic [HOLD_W-1:0] hold_us;
  logic [31:0] prod;

  assign in_stall = front_v_r && !push_ready;
  assign accept   = in_valid && !in_stall;

  // time scaling: hold in us and tick increment in us
  assign dur_fix = (in_duration_ms == 16'd0) ? 16'd1 : in_duration_ms;
  assign hold_us = HOLD_W'(dur_fix) * HOLD_W'(MS_TO_US);
  assign prod    = 32'(in_delta_us) * 32'(speed_q8);

  // classify the beat
  always_comb begin
    cmd_nxt             = '0;
    cmd_nxt.frame_index = in_frame_index;
    cmd_nxt.no_time     = (in_delta_us == 16'd0) || (speed_q8 == 16'd0);
    unique case (in_req_type)
      REQ_TICK: begin
        cmd_nxt.op  = OP_TICK;
        cmd_nxt.arg = HOLD_W'(prod[31:8]);
      end
      REQ_HOLD: begin
        cmd_nxt.op  = OP_HOLD;
        cmd_nxt.arg = hold_us;
      end
      REQ_RESTART: cmd_nxt.op = OP_RESTART;
      REQ_SET:     cmd_nxt.op = OP_SET;
      REQ_STOP:    cmd_nxt.op = OP_STOP;
      default:     cmd_nxt.op = OP_NOP;
    endcase
  end

  // one-entry front register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (accept) begin
      front_v_r <= 1'b1;
    end else if (push_ready) begin
      front_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign push_valid = front_v_r;
  assign push_cmd   = cmd_r;

endmodule

### design/sfs_queue.sv
module sfs_queue
  import sfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != (PW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = ent_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/sfs_back.sv
module sfs_back
  import sfs_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic pop_valid,
  output logic pop_ready,
  input  cmd_t pop_cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int AW    = $clog2(FRAMES);
  localparam int GUARD = 4 * FRAMES;
  localparam int SW    = $clog2(GUARD + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } st_t;

  // hold table in us, undefined until written
  logic [HOLD_W-1:0] hold_mem [FRAMES];
  logic [HOLD_W-1:0] hold_q_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;

  st_t                  st_r, st_nxt;
  logic signed [6:0]    cur_r, cur_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 bb_r, bb_nxt;
  logic                 done_r, done_nxt;
  logic                 active_r, active_nxt;
  logic [SW-1:0]        steps_r, steps_nxt;
  logic                 out_v_r;
  res_t                 out_r;
  logic                 out_load;
  logic [8:0]           res_steps;

  logic              out_free;
  logic              do_pop;
  logic [8:0]        fc9;
  logic signed [8:0] fc_s, first_s, last_s, cur_s;
  logic signed [8:0] nxt_a, nxt_b;
  logic              out_a, out_b;
  logic              backwards, can_bounce, tick_idle;
  logic              guard_hit, stop_walk;
  logic [ELAPSED_W:0]   sum_w;
  logic [ELAPSED_W-1:0] el_sat, el_sub;
  logic              hold_ok;

  function automatic logic [AW-1:0] hold_idx(input logic signed [8:0] f,
                                             input logic signed [8:0] fst,
                                             input logic signed [8:0] lst,
                                             input logic signed [8:0] fcnt);
    logic signed [8:0] sel;
    if (f < 9'sd0) begin
      sel = fst;
    end else if (f >= fcnt) begin
      sel = lst;
    end else begin
      sel = f;
    end
    return AW'($unsigned(sel));
  endfunction

  // clamped range from configuration
  always_comb begin
    fc9     = (9'(cfg.frames_in_sheet) > 9'(FRAMES)) ? 9'(FRAMES) : 9'(cfg.frames_in_sheet);
    fc_s    = $signed(fc9);
    first_s = $signed(9'(cfg.range_first));
    last_s  = (9'(cfg.range_last) >= fc9) ? (fc_s - 9'sd1) : $signed(9'(cfg.range_last));
    cur_s   = 9'(cur_r);
  end

  // one frame step
  always_comb begin
    backwards  = cfg.range_reverse ^ bb_r;
    nxt_a      = backwards ? (cur_s - 9'sd1) : (cur_s + 9'sd1);
    nxt_b      = backwards ? (cur_s + 9'sd1) : (cur_s - 9'sd1);
    out_a      = (nxt_a > last_s) || (nxt_a < first_s);
    out_b      = (nxt_b > last_s) || (nxt_b < first_s);
    can_bounce = cfg.range_bounce && (last_s > first_s);
    guard_hit  = (steps_r == SW'(GUARD));
    stop_walk  = guard_hit || (hold_q_r == '0) ||
                 (elapsed_r < ELAPSED_W'(hold_q_r));
    el_sub     = elapsed_r - ELAPSED_W'(hold_q_r);
  end

  // saturating tick add
  assign sum_w  = {1'b0, elapsed_r} + (ELAPSED_W+1)'(pop_cmd.arg[INC_W-1:0]);
  assign el_sat = sum_w[ELAPSED_W] ? '1 : sum_w[ELAPSED_W-1:0];

  assign tick_idle = !active_r || done_r || (fc9 == 9'd0) || pop_cmd.no_time ||
                     (last_s < first_s);
  assign hold_ok   = !pop_cmd.frame_index[6] &&
                     (9'(pop_cmd.frame_index[5:0]) < 9'(FRAMES));

  assign out_free  = !out_v_r || !res_stall;
  assign pop_ready = (st_r == ST_IDLE) && out_free;
  assign do_pop    = pop_valid && pop_ready;

  // sequencer
  always_comb begin
    st_nxt      = st_r;
    cur_nxt     = cur_r;
    elapsed_nxt = elapsed_r;
    bb_nxt      = bb_r;
    done_nxt    = done_r;
    active_nxt  = active_r;
    steps_nxt   = steps_r;
    out_load    = 1'b0;
    res_steps   = 9'd0;
    mem_we      = 1'b0;
    mem_wa      = AW'(pop_cmd.frame_index[5:0]);
    unique case (st_r)
      ST_IDLE: begin
        if (do_pop) begin
          unique case (pop_cmd.op)
            OP_TICK: begin
              if (tick_idle) begin
                out_load = 1'b1;
              end else begin
                elapsed_nxt = el_sat;
                steps_nxt   = '0;
                st_nxt      = ST_STEP;
              end
            end
            OP_HOLD: begin
              mem_we   = hold_ok;
              out_load = 1'b1;
            end
            OP_RESTART: begin
              if (!(active_r && !done_r)) begin
                active_nxt  = 1'b1;
                done_nxt    = 1'b0;
                bb_nxt      = 1'b0;
                elapsed_nxt = '0;
                cur_nxt     = cfg.range_reverse ? $signed(7'(cfg.range_last))
                                                : $signed(7'(cfg.range_first));
              end
              out_load = 1'b1;
            end
            OP_SET: begin
              cur_nxt     = pop_cmd.frame_index;
              elapsed_nxt = '0;
              done_nxt    = 1'b0;
              out_load    = 1'b1;
            end
            OP_STOP: begin
              done_nxt    = 1'b1;
              elapsed_nxt = '0;
              out_load    = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_STEP: begin
        if (stop_walk) begin
          out_load  = 1'b1;
          res_steps = 9'(steps_r);
          st_nxt    = ST_IDLE;
        end else begin
          steps_nxt   = SW'(steps_r + 1'b1);
          elapsed_nxt = el_sub;
          priority if (!out_a) begin
            cur_nxt = 7'(nxt_a);
          end else if (can_bounce) begin
            bb_nxt  = !bb_r;
            cur_nxt = out_b ? cur_r : 7'(nxt_b);
          end else if (cfg.loop_enable) begin
            cur_nxt = backwards ? 7'(last_s) : 7'(first_s);
          end else begin
            cur_nxt     = backwards ? 7'(first_s) : 7'(last_s);
            done_nxt    = 1'b1;
            elapsed_nxt = '0;
            out_load    = 1'b1;
            res_steps   = 9'(steps_nxt);
            st_nxt      = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign mem_ra = hold_idx(9'(cur_nxt), first_s, last_s, fc_s);

  // hold table port, read follows the next frame
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hold_mem[mem_wa] <= pop_cmd.arg;
    end
    hold_q_r <= hold_mem[mem_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cur_r     <= -7'sd1;
      elapsed_r <= '0;
      bb_r      <= 1'b0;
      done_r    <= 1'b0;
      active_r  <= 1'b0;
      steps_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cur_r     <= cur_nxt;
      elapsed_r <= elapsed_nxt;
      bb_r      <= bb_nxt;
      done_r    <= done_nxt;
      active_r  <= active_nxt;
      steps_r   <= steps_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (!res_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.shown_frame <= cur_nxt;
      out_r.finished    <= done_nxt;
      out_r.playing     <= active_nxt;
      out_r.steps_taken <= res_steps;
    end
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule

### design/sprite_frame_sequencer_top.sv
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   req_type, delta_us, frame_index, duration_ms
// out_      output     out_valid / out_stall shown_frame, finished, playing, steps_taken
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a request crosses a one-beat front register and a two-entry queue, then the back end
// non-tick requests and ticks with nothing to do are answered from the idle state; a tick that
// walks n frames goes through the step state, n up to 4*FRAMES
// one step per cycle set by the hold table read port
// reset is synchronous; the hold table is not cleared and must be written before it is used
// input keeps flowing into the queue while a result waits on out_stall, up to three beats
module sprite_frame_sequencer_top
  import sfs_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [15:0]       in_delta_us,
  input  logic signed [6:0] in_frame_index,
  input  logic [15:0]       in_duration_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [6:0] out_shown_frame,
  output logic              out_finished,
  output logic              out_playing,
  output logic [8:0]        out_steps_taken,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  cfg_t cfg_r;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;
  res_t res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{frames_in_sheet: 7'd0,
                 range_first:     6'd0,
                 range_last:      6'd0,
                 range_reverse:   1'b0,
                 range_bounce:    1'b0,
                 loop_enable:     1'b1,
                 speed_q8:        SPEED_NORMAL};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAMES:  cfg_r.frames_in_sheet <= cfg_data[6:0];
        CFG_FIRST:   cfg_r.range_first     <= cfg_data[5:0];
        CFG_LAST:    cfg_r.range_last      <= cfg_data[5:0];
        CFG_REVERSE: cfg_r.range_reverse   <= cfg_data[0];
        CFG_BOUNCE:  cfg_r.range_bounce    <= cfg_data[0];
        CFG_LOOP:    cfg_r.loop_enable     <= cfg_data[0];
        CFG_SPEED:   cfg_r.speed_q8        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_delta_us    (in_delta_us),
    .in_frame_index (in_frame_index),
    .in_duration_ms (in_duration_ms),
    .speed_q8       (cfg_r.speed_q8),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  sfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sfs_back #(
    .FRAMES (FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign out_shown_frame = res.shown_frame;
  assign out_finished    = res.finished;
  assign out_playing     = res.playing;
  assign out_steps_taken = res.steps_taken;

endmodule

### design/sfs_checker.sv
`include "assert_macros.svh"

module sfs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [6:0] out_shown_frame,
  input logic              out_finished,
  input logic              out_playing,
  input logic [8:0]        out_steps_taken
);

  logic [17:0] out_beat;

  // result payload as one word
  assign out_beat = {out_shown_frame, out_finished, out_playing, out_steps_taken};

  // a stalled result beat stays put
  `SFS_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid)
  `SFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_beat))

  // no frame advances before a restart has started the animation
  `SFS_ASSERT_IMPL(a_idle_no_steps, clk, rst_n, out_valid && !out_playing, out_steps_taken == 9'd0)

  // reset leaves no result pending
  `SFS_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (.*);
